FILE: rtl/gcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared types and constants of the glyph character renderer.
// ----------------------------------------------------------------------------
package gcr_pkg;

    localparam int PALETTE_SIZE = 16;

    typedef enum logic {
        OP_PLOT = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        REG_TEXT_MODE         = 3'd0,
        REG_BITS_PER_PIXEL    = 3'd1,
        REG_GLYPH_WIDTH       = 3'd2,
        REG_GLYPH_HEIGHT      = 3'd3,
        REG_LINE_PITCH        = 3'd4,
        REG_SCREEN_CELLS_WIDE = 3'd5,
        REG_FRAME_BASE        = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_HALF = 2'd1,
        SIZE_WORD = 2'd2
    } wsize_t;

    localparam logic [5:0] BPP_TEXT = 6'd4;
    localparam logic [5:0] BPP_8    = 6'd8;
    localparam logic [5:0] BPP_15   = 6'd15;
    localparam logic [5:0] BPP_16   = 6'd16;
    localparam logic [5:0] BPP_32   = 6'd32;

    localparam logic [3:0] GLYPH_COLS_MAX = 4'd8;

    localparam logic [31:0] PAL565 [PALETTE_SIZE] = '{
        32'h0000, 32'h0014, 32'h0540, 32'h0555, 32'ha000, 32'ha014, 32'ha280, 32'ha554,
        32'h52aa, 32'h52bf, 32'h57ea, 32'h57ff, 32'hfaaa, 32'hfafb, 32'hffea, 32'hffff
    };

    localparam logic [31:0] PALRGB [PALETTE_SIZE] = '{
        32'h000000, 32'h0000aa, 32'h00aa00, 32'h00aaaa,
        32'haa0000, 32'haa00aa, 32'haa5500, 32'haaaaaa,
        32'h555555, 32'h5555ff, 32'h55ff55, 32'h55ffff,
        32'hff5555, 32'hff55ff, 32'hffff55, 32'hffffff
    };

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_font;
        logic start;
        logic mul1;
        logic mul2;
        logic base;
        logic fetch;
        logic emit_single;
        logic emit_pixel;
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic text_mode;
        logic gfx_ok;
        logic last_col;
        logic last_row;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/gcr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/gcr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_ctrl
// Sequencer: font loads; for plots, setup of the start address, then one word or row fetches and pixel words.
// ----------------------------------------------------------------------------
module gcr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic                operation,
    input  gcr_pkg::dp_status_t status,
    output gcr_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MUL1   = 7'b0000010,
        ST_MUL2   = 7'b0000100,
        ST_BASE   = 7'b0001000,
        ST_SINGLE = 7'b0010000,
        ST_FETCH  = 7'b0100000,
        ST_PIXEL  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (operation == gcr_pkg::OP_LOAD)
                    begin
                        cmd.load_font = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                cmd.base = 1'b1;
                if (status.text_mode || !status.gfx_ok)
                begin
                    state_next = ST_SINGLE;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_SINGLE:
            begin
                if (status.out_free)
                begin
                    cmd.emit_single = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_PIXEL;
            end
            ST_PIXEL:
            begin
                if (status.out_free)
                begin
                    cmd.emit_pixel = 1'b1;
                    if (status.last_col)
                    begin
                        state_next = status.last_row ? ST_IDLE : ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a pixel word is only sent with a font row fetched just before the row
    a_fetch_before_row: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch |=> (state_reg == ST_PIXEL))
        else $error("fetch not followed by pixel state");

    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start) |=> !item_ready)
        else $error("input taken during a plot");

    a_emit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_pixel && cmd.emit_single))
        else $error("two result kinds issued at once");

endmodule

FILE: rtl/gcr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_dp
// Datapath: config registers, font store, address arithmetic, result register.
// ----------------------------------------------------------------------------
module gcr_dp #(
    parameter int GLYPH_ROWS_MAX = 8,
    parameter int CHAR_COUNT     = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [7:0]          char_code,
    input  logic [7:0]          cell_column,
    input  logic [7:0]          cell_row,
    input  logic [3:0]          back_color,
    input  logic [3:0]          fore_color,
    input  logic [2:0]          font_row_index,
    input  logic [7:0]          font_row_bits,
    input  gcr_pkg::ctrl_cmd_t  cmd,
    output gcr_pkg::dp_status_t status,
    input  logic                result_ready,
    output logic                result_valid,
    output logic                write_valid,
    output logic [31:0]         write_address,
    output logic [31:0]         write_data,
    output logic [1:0]          write_size,
    output logic                plot_error,
    output logic                last_result
);

    localparam int DEPTH = CHAR_COUNT * GLYPH_ROWS_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (CHAR_COUNT > 1) ? $clog2(CHAR_COUNT) : 1;
    localparam int RW    = (GLYPH_ROWS_MAX > 1) ? $clog2(GLYPH_ROWS_MAX) : 1;

    // configuration
    logic        text_mode_reg;
    logic [5:0]  bpp_reg;
    logic [3:0]  gw_reg;
    logic [3:0]  gh_reg;
    logic [13:0] pitch_reg;
    logic [7:0]  scw_reg;
    logic [31:0] base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_mode_reg <= 1'b0;
            bpp_reg       <= 6'd8;
            gw_reg        <= 4'd8;
            gh_reg        <= 4'd8;
            pitch_reg     <= 14'd320;
            scw_reg       <= 8'd80;
            base_reg      <= 32'h000a_0000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gcr_pkg::REG_TEXT_MODE:         text_mode_reg <= cfg_data[0];
                gcr_pkg::REG_BITS_PER_PIXEL:    bpp_reg       <= cfg_data[5:0];
                gcr_pkg::REG_GLYPH_WIDTH:       gw_reg        <= cfg_data[3:0];
                gcr_pkg::REG_GLYPH_HEIGHT:      gh_reg        <= cfg_data[3:0];
                gcr_pkg::REG_LINE_PITCH:        pitch_reg     <= cfg_data[13:0];
                gcr_pkg::REG_SCREEN_CELLS_WIDE: scw_reg       <= cfg_data[7:0];
                gcr_pkg::REG_FRAME_BASE:        base_reg      <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // derived glyph geometry and pixel format
    logic [3:0]  fw;
    logic [3:0]  fh;
    logic        depth_ok;
    logic [1:0]  shift;
    logic [13:0] stride;

    assign fw = (gw_reg > gcr_pkg::GLYPH_COLS_MAX) ? gcr_pkg::GLYPH_COLS_MAX : gw_reg;
    assign fh = (gh_reg > 4'(GLYPH_ROWS_MAX)) ? 4'(GLYPH_ROWS_MAX) : gh_reg;

    always_comb
    begin
        depth_ok = 1'b1;
        shift    = gcr_pkg::SIZE_BYTE;
        unique case (bpp_reg)
            gcr_pkg::BPP_8:  shift = gcr_pkg::SIZE_BYTE;
            gcr_pkg::BPP_15: shift = gcr_pkg::SIZE_HALF;
            gcr_pkg::BPP_16: shift = gcr_pkg::SIZE_HALF;
            gcr_pkg::BPP_32: shift = gcr_pkg::SIZE_WORD;
            default:         depth_ok = 1'b0;
        endcase
    end

    assign stride = pitch_reg >> shift;

    // character slot table, code wraps at the store size
    logic [CW-1:0] slot_tab [256];

    for (genvar k = 0; k < 256; k++)
    begin : g_slot
        assign slot_tab[k] = CW'(k % CHAR_COUNT);
    end

    // plotted item
    logic [7:0] code_reg;
    logic [7:0] col_reg;
    logic [7:0] row_reg;
    logic [3:0] bg_reg;
    logic [3:0] fg_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            code_reg <= char_code;
            col_reg  <= cell_column;
            row_reg  <= cell_row;
            bg_reg   <= back_color;
            fg_reg   <= fore_color;
        end
    end

    // font store
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [RW-1:0] row_cnt_reg;
    logic [2:0]    col_cnt_reg;

    assign ram_we    = cmd.load_font && ({1'b0, font_row_index} < 4'(GLYPH_ROWS_MAX));
    assign ram_waddr = AW'(slot_tab[char_code] * GLYPH_ROWS_MAX + RW'(font_row_index));
    assign ram_raddr = AW'(slot_tab[code_reg] * GLYPH_ROWS_MAX + row_cnt_reg);

    gcr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_font_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (font_row_bits),
        .re    (cmd.fetch),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // start address, spread over three steps
    logic [15:0] m1_reg;
    logic [10:0] xo_reg;
    logic [24:0] m2_reg;
    logic [25:0] cell_sum;
    logic [27:0] scaled;
    logic [1:0]  addr_shift;
    logic [31:0] row_addr_reg;
    logic [31:0] pix_addr_reg;
    logic [31:0] row_step_reg;
    logic [31:0] pix_step;

    assign addr_shift = text_mode_reg ? gcr_pkg::SIZE_HALF : shift;
    assign cell_sum   = 26'(m2_reg) + 26'(text_mode_reg ? 11'(col_reg) : xo_reg);
    assign scaled     = 28'(cell_sum) << addr_shift;
    assign pix_step   = 32'd1 << shift;

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            m1_reg <= text_mode_reg ? 16'(row_reg) * 16'(scw_reg) : 16'(row_reg) * 16'(fh);
            xo_reg <= 11'(col_reg) * 11'(fw);
        end
        if (cmd.mul2)
        begin
            m2_reg <= text_mode_reg ? 25'(m1_reg) : 25'(m1_reg[10:0]) * 25'(stride);
        end
        if (cmd.base)
        begin
            row_addr_reg <= base_reg + 32'(scaled);
            pix_addr_reg <= base_reg + 32'(scaled);
            row_step_reg <= 32'(stride) << shift;
        end
        else if (cmd.emit_pixel)
        begin
            if (status.last_col)
            begin
                // next glyph row starts one line below this row's start
                row_addr_reg <= row_addr_reg + row_step_reg;
                pix_addr_reg <= row_addr_reg + row_step_reg;
            end
            else
            begin
                pix_addr_reg <= pix_addr_reg + pix_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else if (cmd.base)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else if (cmd.emit_pixel)
        begin
            if (status.last_col)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= row_cnt_reg + RW'(1);
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + 3'd1;
            end
        end
    end

    // pixel value, glyph bits taken msb first
    logic [2:0]  bit_pos;
    logic        pix_on;
    logic [3:0]  pix_idx;
    logic [31:0] pix_data;

    assign bit_pos = 3'(fw - 4'd1 - {1'b0, col_cnt_reg});
    assign pix_on  = ram_rdata[bit_pos];
    assign pix_idx = pix_on ? fg_reg : bg_reg;

    always_comb
    begin
        unique case (shift)
            gcr_pkg::SIZE_HALF: pix_data = gcr_pkg::PAL565[pix_idx];
            gcr_pkg::SIZE_WORD: pix_data = gcr_pkg::PALRGB[pix_idx];
            default:            pix_data = 32'(pix_idx);
        endcase
    end

    // result register
    logic        res_valid_reg;
    logic        wvalid_reg;
    logic [31:0] waddr_reg;
    logic [31:0] wdata_reg;
    logic [1:0]  wsize_reg;
    logic        err_reg;
    logic        last_reg;
    logic        text_ok;

    assign text_ok = (bpp_reg == gcr_pkg::BPP_TEXT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.emit_single || cmd.emit_pixel)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_pixel)
        begin
            wvalid_reg <= 1'b1;
            waddr_reg  <= pix_addr_reg;
            wdata_reg  <= pix_data;
            wsize_reg  <= shift;
            err_reg    <= 1'b0;
            last_reg   <= status.last_col && status.last_row;
        end
        else if (cmd.emit_single)
        begin
            last_reg <= 1'b1;
            if (text_mode_reg && text_ok)
            begin
                wvalid_reg <= 1'b1;
                waddr_reg  <= row_addr_reg;
                wdata_reg  <= {16'd0, bg_reg, fg_reg, code_reg};
                wsize_reg  <= gcr_pkg::SIZE_HALF;
                err_reg    <= 1'b0;
            end
            else
            begin
                // wrong text depth flags an error, bad graphics setup writes nothing
                wvalid_reg <= 1'b0;
                waddr_reg  <= '0;
                wdata_reg  <= '0;
                wsize_reg  <= gcr_pkg::SIZE_BYTE;
                err_reg    <= text_mode_reg;
            end
        end
    end

    assign result_valid  = res_valid_reg;
    assign write_valid   = wvalid_reg;
    assign write_address = waddr_reg;
    assign write_data    = wdata_reg;
    assign write_size    = wsize_reg;
    assign plot_error    = err_reg;
    assign last_result   = last_reg;

    assign status.text_mode = text_mode_reg;
    assign status.gfx_ok    = depth_ok && (fw != 4'd0) && (fh != 4'd0);
    assign status.last_col  = ({1'b0, col_cnt_reg} == (fw - 4'd1));
    assign status.last_row  = (4'(row_cnt_reg) == (fh - 4'd1));
    assign status.out_free  = !res_valid_reg || result_ready;

endmodule

FILE: rtl/glyph_character_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_character_renderer
// Turns character plots into frame buffer write words; loads font rows.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  item      item_valid / item_ready   operation, char_code, cell_column,
//                                      cell_row, back_color, fore_color,
//                                      font_row_index, font_row_bits
//  result    result_valid/result_ready write_valid, write_address, write_data,
//                                      write_size, plot_error, last_result
//  cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  font load: no result word
//  text plot or no-write plot: a single result word
//  graphics plot: one font store read per glyph row, then one pixel word per
//  cycle from the result register while that register can take a word
//  reset loads the register defaults; font rows are undefined until loaded
//  result_ready low holds the result register and pauses the pixel sequence
// ----------------------------------------------------------------------------
module glyph_character_renderer #(
    parameter int GLYPH_ROWS_MAX = 8,
    parameter int CHAR_COUNT     = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        operation,
    input  logic [7:0]  char_code,
    input  logic [7:0]  cell_column,
    input  logic [7:0]  cell_row,
    input  logic [3:0]  back_color,
    input  logic [3:0]  fore_color,
    input  logic [2:0]  font_row_index,
    input  logic [7:0]  font_row_bits,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        write_valid,
    output logic [31:0] write_address,
    output logic [31:0] write_data,
    output logic [1:0]  write_size,
    output logic        plot_error,
    output logic        last_result
);

    gcr_pkg::ctrl_cmd_t  cmd;
    gcr_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    gcr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .operation  (operation),
        .status     (status),
        .cmd        (cmd)
    );

    gcr_dp #(
        .GLYPH_ROWS_MAX (GLYPH_ROWS_MAX),
        .CHAR_COUNT     (CHAR_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .char_code      (char_code),
        .cell_column    (cell_column),
        .cell_row       (cell_row),
        .back_color     (back_color),
        .fore_color     (fore_color),
        .font_row_index (font_row_index),
        .font_row_bits  (font_row_bits),
        .cmd            (cmd),
        .status         (status),
        .result_ready   (result_ready),
        .result_valid   (result_valid),
        .write_valid    (write_valid),
        .write_address  (write_address),
        .write_data     (write_data),
        .write_size     (write_size),
        .plot_error     (plot_error),
        .last_result    (last_result)
    );

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && operation == gcr_pkg::OP_LOAD && !result_valid)
        |=> !result_valid)
        else $error("font load produced a result word");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && plot_error) |-> (!write_valid && last_result))
        else $error("error word is not a final no-write word");

    a_nowrite_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !write_valid) |-> last_result)
        else $error("no-write word is not final");

    a_plot_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && operation == gcr_pkg::OP_PLOT) |=> !item_ready)
        else $error("input ready right after a plot was taken");

endmodule

FILE: dv/glyph_character_renderer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_character_renderer_tb
// Self-checking bench for the glyph character renderer. A short table of
// directed plots, font loads and register writes runs first, with obvious words typed in.
// Randomized phases follow, each under a fresh register setting. A local
// predictor turns each untyped accepted plot into frame buffer words it
// should produce, and each result word is checked in order against them.
// ----------------------------------------------------------------------------
module glyph_character_renderer_tb;

    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int END_CYCLES      = 32;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 49;

    localparam logic [15:0] RGB565_LUT [16] = '{
        16'h0000, 16'h0014, 16'h0540, 16'h0555, 16'ha000, 16'ha014, 16'ha280, 16'ha554,
        16'h52aa, 16'h52bf, 16'h57ea, 16'h57ff, 16'hfaaa, 16'hfafb, 16'hffea, 16'hffff
    };

    localparam logic [23:0] RGB888_LUT [16] = '{
        24'h000000, 24'h0000aa, 24'h00aa00, 24'h00aaaa,
        24'haa0000, 24'haa00aa, 24'haa5500, 24'haaaaaa,
        24'h555555, 24'h5555ff, 24'h55ff55, 24'h55ffff,
        24'hff5555, 24'hff55ff, 24'hffff55, 24'hffffff
    };

    typedef struct packed {
        gcr_pkg::op_t operation;
        logic [7:0]   code;
        logic [7:0]   col;
        logic [7:0]   row;
        logic [3:0]   back;
        logic [3:0]   fore;
        logic [2:0]   font_row;
        logic [7:0]   bits;
    } char_item_t;

    typedef struct packed {
        logic            write_valid;
        logic [31:0]     write_address;
        logic [31:0]     write_data;
        gcr_pkg::wsize_t write_size;
        logic            plot_error;
        logic            last_result;
    } write_word_t;

    typedef struct packed {
        bit                  is_cfg;
        gcr_pkg::reg_index_t reg_sel;
        logic [31:0]         reg_value;
        char_item_t          item;
        bit                  typed;
        write_word_t         want;
    } step_t;

    localparam write_word_t NO_WRITE   = '{1'b0, 32'd0, 32'd0, gcr_pkg::SIZE_BYTE, 1'b0, 1'b1};
    localparam write_word_t PLOT_FAULT = '{1'b0, 32'd0, 32'd0, gcr_pkg::SIZE_BYTE, 1'b1, 1'b1};

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        item_valid;
    logic        item_ready;
    logic        operation;
    logic [7:0]  char_code;
    logic [7:0]  cell_column;
    logic [7:0]  cell_row;
    logic [3:0]  back_color;
    logic [3:0]  fore_color;
    logic [2:0]  font_row_index;
    logic [7:0]  font_row_bits;
    logic        result_valid;
    logic        result_ready;
    logic        write_valid;
    logic [31:0] write_address;
    logic [31:0] write_data;
    logic [1:0]  write_size;
    logic        plot_error;
    logic        last_result;

    // local copy of the block state
    logic [31:0] cfg_text;
    logic [31:0] cfg_bpp;
    logic [31:0] cfg_gw;
    logic [31:0] cfg_gh;
    logic [31:0] cfg_pitch;
    logic [31:0] cfg_cells;
    logic [31:0] cfg_base;
    logic [7:0]  glyph_rows [0:2047];
    bit          row_written [0:2047];

    write_word_t pending_writes [$];
    logic [7:0]  used_codes [$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          calm = 1'b0;

    glyph_character_renderer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .operation      (operation),
        .char_code      (char_code),
        .cell_column    (cell_column),
        .cell_row       (cell_row),
        .back_color     (back_color),
        .fore_color     (fore_color),
        .font_row_index (font_row_index),
        .font_row_bits  (font_row_bits),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .write_valid    (write_valid),
        .write_address  (write_address),
        .write_data     (write_data),
        .write_size     (write_size),
        .plot_error     (plot_error),
        .last_result    (last_result)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    // expand one accepted plot into the words it should produce
    function automatic void expand_character(char_item_t it);
        logic [31:0]     fw;
        logic [31:0]     fh;
        logic [31:0]     shift;
        logic [31:0]     stride;
        logic [31:0]     x;
        logic [31:0]     y;
        logic [7:0]      bits;
        logic [3:0]      idx;
        gcr_pkg::wsize_t size;
        int              n;
        write_word_t     w;

        if (cfg_text != 0)
        begin
            if (cfg_bpp == 32'(gcr_pkg::BPP_TEXT))
            begin
                w.write_valid   = 1'b1;
                w.write_address = cfg_base + (it.row * cfg_cells + it.col) * 2;
                w.write_data    = {16'h0000, it.back, it.fore, it.code};
                w.write_size    = gcr_pkg::SIZE_HALF;
                w.plot_error    = 1'b0;
                w.last_result   = 1'b1;
            end
            else
                w = PLOT_FAULT;
            pending_writes.push_back(w);
            return;
        end

        case (cfg_bpp)
            32'(gcr_pkg::BPP_8):
            begin
                size  = gcr_pkg::SIZE_BYTE;
                shift = 0;
            end
            32'(gcr_pkg::BPP_15), 32'(gcr_pkg::BPP_16):
            begin
                size  = gcr_pkg::SIZE_HALF;
                shift = 1;
            end
            32'(gcr_pkg::BPP_32):
            begin
                size  = gcr_pkg::SIZE_WORD;
                shift = 2;
            end
            default:
            begin
                pending_writes.push_back(NO_WRITE);
                return;
            end
        endcase

        fw = (cfg_gw > 8) ? 32'd8 : cfg_gw;
        fh = (cfg_gh > 8) ? 32'd8 : cfg_gh;
        if (fw == 0 || fh == 0)
        begin
            pending_writes.push_back(NO_WRITE);
            return;
        end

        stride = cfg_pitch >> shift;
        n = 0;
        for (int i = 0; i < fh; i++)
        begin
            bits = glyph_rows[int'(it.code) * 8 + i];
            y    = it.row * fh + 32'(i);
            for (int j = 0; j < fw; j++)
            begin
                idx = bits[fw - 1 - 32'(j)] ? it.fore : it.back;
                x   = it.col * fw + 32'(j);
                n++;
                w.write_valid   = 1'b1;
                w.write_address = cfg_base + ((y * stride + x) << shift);
                w.write_size    = size;
                w.plot_error    = 1'b0;
                w.last_result   = (32'(n) == fw * fh);
                if (size == gcr_pkg::SIZE_BYTE)
                    w.write_data = {28'd0, idx};
                else if (size == gcr_pkg::SIZE_HALF)
                    w.write_data = {16'd0, RGB565_LUT[idx]};
                else
                    w.write_data = {8'd0, RGB888_LUT[idx]};
                pending_writes.push_back(w);
            end
        end
    endfunction

    task automatic check_write();
        write_word_t want;

        if (pending_writes.size() == 0)
        begin
            report_mismatch("word with nothing pending", write_address, 32'd0);
            return;
        end
        want = pending_writes.pop_front();
        if (write_valid !== want.write_valid)
            report_mismatch("write_valid", 32'(write_valid), 32'(want.write_valid));
        if (write_address !== want.write_address)
            report_mismatch("write_address", write_address, want.write_address);
        if (write_data !== want.write_data)
            report_mismatch("write_data", write_data, want.write_data);
        if (write_size !== want.write_size)
            report_mismatch("write_size", 32'(write_size), 32'(want.write_size));
        if (plot_error !== want.plot_error)
            report_mismatch("plot_error", 32'(plot_error), 32'(want.plot_error));
        if (last_result !== want.last_result)
            report_mismatch("last_result", 32'(last_result), 32'(want.last_result));
    endtask

    always @(posedge clk)
        if (rst_n && result_valid && result_ready)
            check_write();

    // receiver: ready stretches broken by stall bursts outside the calm phase
    initial
    begin
        int unsigned run;

        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        result_ready <= 1'b1;
        forever
        begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
            repeat (run) @(negedge clk);
            if (!calm)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                result_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(gcr_pkg::reg_index_t sel, logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (sel)
            gcr_pkg::REG_TEXT_MODE:         cfg_text  = value & 32'h1;
            gcr_pkg::REG_BITS_PER_PIXEL:    cfg_bpp   = value & 32'h3f;
            gcr_pkg::REG_GLYPH_WIDTH:       cfg_gw    = value & 32'hf;
            gcr_pkg::REG_GLYPH_HEIGHT:      cfg_gh    = value & 32'hf;
            gcr_pkg::REG_LINE_PITCH:        cfg_pitch = value & 32'h3fff;
            gcr_pkg::REG_SCREEN_CELLS_WIDE: cfg_cells = value & 32'hff;
            gcr_pkg::REG_FRAME_BASE:        cfg_base  = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(char_item_t it, bit typed = 1'b0, write_word_t want = NO_WRITE);
        @(negedge clk);
        item_valid     <= 1'b1;
        operation      <= it.operation;
        char_code      <= it.code;
        cell_column    <= it.col;
        cell_row       <= it.row;
        back_color     <= it.back;
        fore_color     <= it.fore;
        font_row_index <= it.font_row;
        font_row_bits  <= it.bits;
        do
            @(posedge clk);
        while (!item_ready);
        if (it.operation == gcr_pkg::OP_LOAD)
        begin
            glyph_rows[int'(it.code) * 8 + int'(it.font_row)]  = it.bits;
            row_written[int'(it.code) * 8 + int'(it.font_row)] = 1'b1;
        end
        else if (typed)
            pending_writes.push_back(want);
        else
            expand_character(it);
    endtask

    task automatic sender_gap();
        int n;

        n = $urandom_range(1, 14);
        @(negedge clk);
        item_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // hold the sender off until every pending word is out and loads have landed
    task automatic wait_idle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic step_t reg_row(gcr_pkg::reg_index_t sel, logic [31:0] value);
        step_t s;

        s           = '0;
        s.is_cfg    = 1'b1;
        s.reg_sel   = sel;
        s.reg_value = value;
        return s;
    endfunction

    function automatic step_t load_row(logic [7:0] code, logic [2:0] font_row, logic [7:0] bits);
        step_t s;

        s                 = '0;
        s.item.operation  = gcr_pkg::OP_LOAD;
        s.item.code       = code;
        s.item.font_row   = font_row;
        s.item.bits       = bits;
        return s;
    endfunction

    function automatic step_t plot_row(logic [7:0] code, logic [7:0] col, logic [7:0] row,
                                       logic [3:0] back, logic [3:0] fore,
                                       bit typed = 1'b0, write_word_t want = NO_WRITE);
        step_t s;

        s                = '0;
        s.item.operation = gcr_pkg::OP_PLOT;
        s.item.code      = code;
        s.item.col       = col;
        s.item.row       = row;
        s.item.back      = back;
        s.item.fore      = fore;
        s.typed          = typed;
        s.want           = want;
        return s;
    endfunction

    function automatic logic [31:0] pick_span(logic [31:0] hi);
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return hi;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    function automatic logic [31:0] pick_glyph_size();
        if ($urandom_range(0, 6) != 0)
            return $urandom_range(1, 8);
        return $urandom_range(0, 15);
    endfunction

    initial
    begin
        step_t       step;
        step_t       directed_steps [$];
        logic [7:0]  code;
        logic [31:0] mode;
        logic [31:0] fw;
        logic [31:0] fh;
        int          sent;
        bit          gfx_reads;
        bit          paused;

        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        item_valid     = 1'b0;
        operation      = 1'b0;
        char_code      = '0;
        cell_column    = '0;
        cell_row       = '0;
        back_color     = '0;
        fore_color     = '0;
        font_row_index = '0;
        font_row_bits  = '0;
        cfg_text       = 0;
        cfg_bpp        = 8;
        cfg_gw         = 8;
        cfg_gh         = 8;
        cfg_pitch      = 320;
        cfg_cells      = 80;
        cfg_base       = 32'h000a_0000;
        paused         = 1'b0;
        foreach (row_written[k])
            row_written[k] = 1'b0;

        // full glyph for code 0, then plots under the reset setting
        directed_steps.push_back(load_row(8'h00, 3'd0, 8'h00));
        directed_steps.push_back(load_row(8'h00, 3'd1, 8'hff));
        directed_steps.push_back(load_row(8'h00, 3'd2, 8'h80));
        directed_steps.push_back(load_row(8'h00, 3'd3, 8'h01));
        directed_steps.push_back(load_row(8'h00, 3'd4, 8'haa));
        directed_steps.push_back(load_row(8'h00, 3'd5, 8'h55));
        directed_steps.push_back(load_row(8'h00, 3'd6, 8'h0f));
        directed_steps.push_back(load_row(8'h00, 3'd7, 8'hf0));
        directed_steps.push_back(plot_row(8'h00, 8'd0, 8'd0, 4'd0, 4'd15));
        directed_steps.push_back(plot_row(8'h00, 8'd255, 8'd255, 4'd15, 4'd0));
        // text mode at the wrong depth
        directed_steps.push_back(reg_row(gcr_pkg::REG_TEXT_MODE, 32'd1));
        directed_steps.push_back(plot_row(8'h41, 8'd3, 8'd2, 4'd1, 4'd14, 1'b1, PLOT_FAULT));
        // text cells at both address extremes
        directed_steps.push_back(reg_row(gcr_pkg::REG_BITS_PER_PIXEL, 32'd4));
        directed_steps.push_back(reg_row(gcr_pkg::REG_SCREEN_CELLS_WIDE, 32'd255));
        directed_steps.push_back(plot_row(8'hff, 8'd255, 8'd255, 4'd15, 4'd15, 1'b1,
                                          '{1'b1, 32'h000b_fe00, 32'h0000_ffff,
                                            gcr_pkg::SIZE_HALF, 1'b0, 1'b1}));
        directed_steps.push_back(reg_row(gcr_pkg::REG_SCREEN_CELLS_WIDE, 32'd0));
        directed_steps.push_back(reg_row(gcr_pkg::REG_FRAME_BASE, 32'd0));
        directed_steps.push_back(plot_row(8'h00, 8'd255, 8'd255, 4'd0, 4'd0, 1'b1,
                                          '{1'b1, 32'h0000_01fe, 32'h0,
                                            gcr_pkg::SIZE_HALF, 1'b0, 1'b1}));
        // graphics depth that writes nothing
        directed_steps.push_back(reg_row(gcr_pkg::REG_TEXT_MODE, 32'd0));
        directed_steps.push_back(reg_row(gcr_pkg::REG_BITS_PER_PIXEL, 32'd5));
        directed_steps.push_back(plot_row(8'h00, 8'd9, 8'd4, 4'd2, 4'd3, 1'b1, NO_WRITE));
        // zero width glyph
        directed_steps.push_back(reg_row(gcr_pkg::REG_BITS_PER_PIXEL, 32'd16));
        directed_steps.push_back(reg_row(gcr_pkg::REG_GLYPH_WIDTH, 32'd0));
        directed_steps.push_back(plot_row(8'h00, 8'd1, 8'd1, 4'd5, 4'd6, 1'b1, NO_WRITE));
        // oversized width saturates, address wraps past the top
        directed_steps.push_back(reg_row(gcr_pkg::REG_GLYPH_WIDTH, 32'd15));
        directed_steps.push_back(reg_row(gcr_pkg::REG_GLYPH_HEIGHT, 32'd1));
        directed_steps.push_back(reg_row(gcr_pkg::REG_BITS_PER_PIXEL, 32'd15));
        directed_steps.push_back(reg_row(gcr_pkg::REG_LINE_PITCH, 32'd16383));
        directed_steps.push_back(reg_row(gcr_pkg::REG_FRAME_BASE, 32'hffff_fff0));
        directed_steps.push_back(load_row(8'hff, 3'd0, 8'h5a));
        directed_steps.push_back(plot_row(8'hff, 8'd255, 8'd255, 4'd7, 4'd9));
        directed_steps.push_back(plot_row(8'h00, 8'd1, 8'd0, 4'd3, 4'd12));
        // 32 bpp, oversized height saturates, zero pitch
        directed_steps.push_back(reg_row(gcr_pkg::REG_BITS_PER_PIXEL, 32'd32));
        directed_steps.push_back(reg_row(gcr_pkg::REG_GLYPH_HEIGHT, 32'd15));
        directed_steps.push_back(reg_row(gcr_pkg::REG_GLYPH_WIDTH, 32'd3));
        directed_steps.push_back(reg_row(gcr_pkg::REG_LINE_PITCH, 32'd0));
        directed_steps.push_back(plot_row(8'h00, 8'd17, 8'd9, 4'd8, 4'd6));
        // zero height glyph
        directed_steps.push_back(reg_row(gcr_pkg::REG_GLYPH_HEIGHT, 32'd0));
        directed_steps.push_back(plot_row(8'h00, 8'd0, 8'd0, 4'd0, 4'd0, 1'b1, NO_WRITE));
        // top of the depth range
        directed_steps.push_back(reg_row(gcr_pkg::REG_GLYPH_HEIGHT, 32'd8));
        directed_steps.push_back(reg_row(gcr_pkg::REG_BITS_PER_PIXEL, 32'd63));
        directed_steps.push_back(plot_row(8'h00, 8'd2, 8'd2, 4'd4, 4'd4, 1'b1, NO_WRITE));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[k])
        begin
            step = directed_steps[k];
            if (step.is_cfg)
            begin
                wait_idle();
                write_reg(step.reg_sel, step.reg_value);
            end
            else
            begin
                if ($urandom_range(0, 4) == 0)
                    sender_gap();
                send_item(step.item, step.typed, step.want);
            end
        end
        used_codes.push_back(8'h00);
        used_codes.push_back(8'hff);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
                calm = 1'b1;
            wait_idle();

            mode = 32'($urandom_range(0, 3) == 0);
            write_reg(gcr_pkg::REG_TEXT_MODE, mode);
            if (mode != 0)
                write_reg(gcr_pkg::REG_BITS_PER_PIXEL,
                          ($urandom_range(0, 3) != 0) ? 32'(gcr_pkg::BPP_TEXT)
                                                      : $urandom_range(0, 63));
            else if ($urandom_range(0, 4) != 0)
                case ($urandom_range(0, 3))
                    0:       write_reg(gcr_pkg::REG_BITS_PER_PIXEL, 32'(gcr_pkg::BPP_8));
                    1:       write_reg(gcr_pkg::REG_BITS_PER_PIXEL, 32'(gcr_pkg::BPP_15));
                    2:       write_reg(gcr_pkg::REG_BITS_PER_PIXEL, 32'(gcr_pkg::BPP_16));
                    default: write_reg(gcr_pkg::REG_BITS_PER_PIXEL, 32'(gcr_pkg::BPP_32));
                endcase
            else
                write_reg(gcr_pkg::REG_BITS_PER_PIXEL, $urandom_range(0, 63));
            write_reg(gcr_pkg::REG_GLYPH_WIDTH, pick_glyph_size());
            write_reg(gcr_pkg::REG_GLYPH_HEIGHT, pick_glyph_size());
            write_reg(gcr_pkg::REG_LINE_PITCH, pick_span(32'd16383));
            write_reg(gcr_pkg::REG_SCREEN_CELLS_WIDE, pick_span(32'd255));
            write_reg(gcr_pkg::REG_FRAME_BASE, pick_span(32'hffff_ffff));

            fw = (cfg_gw > 8) ? 32'd8 : cfg_gw;
            fh = (cfg_gh > 8) ? 32'd8 : cfg_gh;
            gfx_reads = (cfg_text == 0) && fw != 0 && fh != 0 &&
                        (cfg_bpp == 32'(gcr_pkg::BPP_8) || cfg_bpp == 32'(gcr_pkg::BPP_15) ||
                         cfg_bpp == 32'(gcr_pkg::BPP_16) || cfg_bpp == 32'(gcr_pkg::BPP_32));

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                if (p == 3 && !paused && sent >= ITEMS_PER_PHASE / 2)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
                if (!calm && $urandom_range(0, 4) == 0)
                    sender_gap();

                if ($urandom_range(0, 6) == 0)
                begin
                    // stray font load
                    step = load_row(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                                    8'($urandom_range(0, 255)));
                    send_item(step.item);
                    sent++;
                end
                else
                begin
                    if (used_codes.size() != 0 && $urandom_range(0, 2) != 0)
                        code = used_codes[$urandom_range(0, used_codes.size() - 1)];
                    else
                    begin
                        code = 8'($urandom_range(0, 255));
                        used_codes.push_back(code);
                    end
                    // a graphics plot only reads rows that were loaded first
                    if (gfx_reads)
                        for (int r = 0; r < fh; r++)
                            if (!row_written[int'(code) * 8 + r])
                            begin
                                step = load_row(code, 3'(r), 8'($urandom_range(0, 255)));
                                send_item(step.item);
                                sent++;
                            end
                    step = plot_row(code, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
                    send_item(step.item);
                    sent++;
                end
            end
        end

        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (pending_writes.size() != 0)
            report_mismatch("words never written", 32'(pending_writes.size()), 32'd0);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/gcr_pkg.sv
rtl/gcr_ram.sv
rtl/gcr_ctrl.sv
rtl/gcr_dp.sv
rtl/glyph_character_renderer.sv
dv/glyph_character_renderer_tb.sv
